### hw/rtl/sqs_pkg.sv
`timescale 1ns / 1ps

package sqs_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PRIO_W      = 9;
    localparam int CPLX_W      = 5;
    localparam int ATT_W       = 4;
    localparam int MAX_CPLX    = 20;

    typedef enum logic [2:0] {
        EV_IDLE       = 3'd0,
        EV_DISPATCHED = 3'd1,
        EV_RUNNING    = 3'd2,
        EV_FINISHED   = 3'd3,
        EV_REQUEUED   = 3'd4,
        EV_DROPPED    = 3'd5
    } event_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // One operation per cycle on a queue: insert a value or pop the head.
    typedef struct packed {
        logic              ins;
        logic              pop;
        logic [PRIO_W-1:0] value;
    } q_op_t;

    typedef struct packed {
        logic [PRIO_W-1:0] head;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  count_next;
        logic              full;
        logic              empty;
    } q_stat_t;

endpackage

### hw/rtl/sqs_cell.sv
`timescale 1ns / 1ps

module sqs_cell
    import sqs_pkg::*;
(
    input  logic              clk,
    input  logic              occ,
    input  q_op_t             op,
    input  logic              left_take,
    input  logic [PRIO_W-1:0] left_val,
    input  logic [PRIO_W-1:0] right_val,
    output logic              take,
    output logic [PRIO_W-1:0] val
);

    logic [PRIO_W-1:0] val_reg;
    logic [PRIO_W-1:0] val_next;

    // The queue is ascending from the head, so the cells that take part in an
    // insert form one contiguous run up to the tail. An empty cell always takes.
    assign take = !occ || (val_reg >= op.value);

    always_comb
    begin
        val_next = val_reg;
        if (op.ins)
        begin
            if (take)
            begin
                val_next = left_take ? left_val : op.value;
            end
        end
        else if (op.pop)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

### hw/rtl/sqs_queue.sv
`timescale 1ns / 1ps

module sqs_queue
    import sqs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_op_t   op,
    output q_stat_t stat
);

    logic [PRIO_W-1:0]      val [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] take;
    logic [QUEUE_DEPTH-1:0] occ;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        logic              lt;
        logic [PRIO_W-1:0] lv;
        logic [PRIO_W-1:0] rv;

        assign occ[g] = (CNT_W'(g) < count_reg);

        if (g == 0)
        begin : g_first
            assign lt = 1'b0;
            assign lv = '0;
        end
        else
        begin : g_mid
            assign lt = take[g-1];
            assign lv = val[g-1];
        end

        if (g == QUEUE_DEPTH - 1)
        begin : g_last
            assign rv = val[g];
        end
        else
        begin : g_inner
            assign rv = val[g+1];
        end

        sqs_cell u_cell (
            .clk       (clk),
            .occ       (occ[g]),
            .op        (op),
            .left_take (lt),
            .left_val  (lv),
            .right_val (rv),
            .take      (take[g]),
            .val       (val[g])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (op.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (op.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign stat.head       = val[0];
    assign stat.count      = count_reg;
    assign stat.count_next = count_next;
    assign stat.full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty      = (count_reg == '0);

endmodule

### hw/rtl/two_queue_priority_scheduler.sv
// A transaction's arrival insert runs in the idle state and its dispatch or requeue on
// the same cell chains in the exec state, which waits while a prior result is unread and
// registers the result; no new transaction is taken until the exec state is done.
// A new transaction may be accepted while the previous result still waits at the output.
// Reset clears the queue counts, the running job and the handshake state; the queue cells
// themselves are not cleared and are only read below the count.
`timescale 1ns / 1ps

module two_queue_priority_scheduler
    import sqs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              arrive_valid,
    input  logic              arrive_queue,
    input  logic [PRIO_W-1:0] arrive_priority,
    input  logic [CPLX_W-1:0] new_complexity,
    input  logic              finish_now,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        event_res,
    output logic              arrival_dropped,
    output logic [PRIO_W-1:0] job_priority,
    output logic              job_queue,
    output logic [CPLX_W-1:0] job_complexity,
    output logic [6:0]        count_one,
    output logic [6:0]        count_two
);

    state_t            state_reg, state_next;
    logic              in_fire;
    logic              exec_go;

    logic [CPLX_W-1:0] nc_reg;
    logic              fin_reg;
    logic              drop_reg;

    logic [PRIO_W-1:0] run_prio_reg, run_prio_next;
    logic              run_queue_reg, run_queue_next;
    logic [CPLX_W-1:0] run_cplx_reg, run_cplx_next;
    logic [ATT_W-1:0]  attempt_reg, attempt_next;

    logic              out_valid_reg;
    event_t            ev_reg, ev_next;
    logic              od_reg;
    logic [PRIO_W-1:0] jp_reg, jp_next;
    logic              jq_reg, jq_next;
    logic [CPLX_W-1:0] jc_reg, jc_next;
    logic [6:0]        c1_reg;
    logic [6:0]        c2_reg;

    q_op_t             op1, op2;
    q_op_t             ex1, ex2;
    q_stat_t           st1, st2;
    logic [CPLX_W-1:0] nc_clamped;
    logic              take_one;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs of the state machine.
    always_comb
    begin
        in_ready = 1'b0;
        exec_go  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_EXEC:
            begin
                exec_go = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign in_fire = in_valid && in_ready;

    always_comb
    begin
        if (nc_reg == '0)
        begin
            nc_clamped = CPLX_W'(1);
        end
        else if (nc_reg > CPLX_W'(MAX_CPLX))
        begin
            nc_clamped = CPLX_W'(MAX_CPLX);
        end
        else
        begin
            nc_clamped = nc_reg;
        end
    end

    assign take_one = st2.empty || (!st1.empty && (st1.head <= st2.head));

    // Exec state of a transaction: dispatch, or advance, finish or requeue the running job.
    always_comb
    begin
        ex1            = '0;
        ex2            = '0;
        ex1.value      = run_prio_reg;
        ex2.value      = run_prio_reg;
        run_prio_next  = run_prio_reg;
        run_queue_next = run_queue_reg;
        run_cplx_next  = run_cplx_reg;
        attempt_next   = attempt_reg;
        ev_next        = EV_IDLE;
        jp_next        = '0;
        jq_next        = 1'b0;
        jc_next        = '0;
        if (run_cplx_reg == '0)
        begin
            if (!st1.empty || !st2.empty)
            begin
                ex1.pop        = take_one;
                ex2.pop        = !take_one;
                run_prio_next  = take_one ? st1.head : st2.head;
                run_queue_next = !take_one;
                run_cplx_next  = nc_clamped;
                attempt_next   = '0;
                ev_next        = EV_DISPATCHED;
                jp_next        = run_prio_next;
                jq_next        = run_queue_next;
                jc_next        = nc_clamped;
            end
        end
        else
        begin
            jp_next = run_prio_reg;
            jq_next = run_queue_reg;
            jc_next = run_cplx_reg;
            if (fin_reg)
            begin
                ev_next       = EV_FINISHED;
                run_cplx_next = '0;
                attempt_next  = '0;
            end
            else if (CPLX_W'(attempt_reg) < (run_cplx_reg >> 1))
            begin
                ev_next      = EV_RUNNING;
                attempt_next = attempt_reg + ATT_W'(1);
            end
            else
            begin
                run_cplx_next = '0;
                attempt_next  = '0;
                ev_next       = EV_REQUEUED;
                // A job from a full queue one falls back to queue two.
                if (!run_queue_reg && !st1.full)
                begin
                    ex1.ins = 1'b1;
                end
                else if (!st2.full)
                begin
                    ex2.ins = 1'b1;
                end
                else
                begin
                    ev_next = EV_DROPPED;
                end
            end
        end
    end

    always_comb
    begin
        op1 = '0;
        op2 = '0;
        if (in_fire)
        begin
            op1.ins   = arrive_valid && !arrive_queue && !st1.full;
            op1.value = arrive_priority;
            op2.ins   = arrive_valid && arrive_queue && !st2.full;
            op2.value = arrive_priority;
        end
        else if (exec_go)
        begin
            op1 = ex1;
            op2 = ex2;
        end
    end

    sqs_queue u_queue_one (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op1),
        .stat  (st1)
    );

    sqs_queue u_queue_two (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op2),
        .stat  (st2)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            run_prio_reg  <= '0;
            run_queue_reg <= 1'b0;
            run_cplx_reg  <= '0;
            attempt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_go)
            begin
                out_valid_reg <= 1'b1;
                run_prio_reg  <= run_prio_next;
                run_queue_reg <= run_queue_next;
                run_cplx_reg  <= run_cplx_next;
                attempt_reg   <= attempt_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            nc_reg   <= new_complexity;
            fin_reg  <= finish_now;
            drop_reg <= arrive_valid && (arrive_queue ? st2.full : st1.full);
        end
        if (exec_go)
        begin
            ev_reg <= ev_next;
            od_reg <= drop_reg;
            jp_reg <= jp_next;
            jq_reg <= jq_next;
            jc_reg <= jc_next;
            c1_reg <= 7'(st1.count_next);
            c2_reg <= 7'(st2.count_next);
        end
    end

    assign out_valid       = out_valid_reg;
    assign event_res       = ev_reg;
    assign arrival_dropped = od_reg;
    assign job_priority    = jp_reg;
    assign job_queue       = jq_reg;
    assign job_complexity  = jc_reg;
    assign count_one       = c1_reg;
    assign count_two       = c2_reg;

    a_count_one_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st1.count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue one count above depth");

    a_count_two_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st2.count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue two count above depth");

    a_attempt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CPLX_W'(attempt_reg) <= (run_cplx_reg >> 1))
        else $error("attempt count above half the complexity");

    a_cplx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_cplx_reg <= CPLX_W'(MAX_CPLX))
        else $error("running complexity out of range");

    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(op1.ins && op1.pop) && !(op2.ins && op2.pop))
        else $error("insert and pop on one queue in the same cycle");

    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("result not presented after execution cycle");

endmodule
